// ----- design/mqlf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqlf_pkg
// Shared widths, codes and defaults for the multi-queue linked FIFO.
// ----------------------------------------------------------------------------
package mqlf_pkg;

    // payload field widths
    localparam int MODE_W   = 1;
    localparam int QSEL_W   = 2;
    localparam int ID_W     = 16;
    localparam int GRADE_W  = 8;
    localparam int STATUS_W = 2;
    localparam int REC_W    = ID_W + GRADE_W;

    // parameter defaults
    localparam int NUM_QUEUES_DEF = 3;
    localparam int POOL_DEPTH_DEF = 64;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ENQ = 1'b0;
    localparam logic [MODE_W-1:0] MODE_DEQ = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [STATUS_W-1:0] t_status;

endpackage

// ----- design/mqlf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqlf_in_if / mqlf_out_if
// Valid/ready channels for queue operations and their results.
// ----------------------------------------------------------------------------

// operation channel
interface mqlf_in_if;
    import mqlf_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [QSEL_W-1:0]  queue_sel;
    logic [ID_W-1:0]    rec_id;
    logic [GRADE_W-1:0] rec_grade;

    modport source (output valid, mode, queue_sel, rec_id, rec_grade, input ready);
    modport sink   (input valid, mode, queue_sel, rec_id, rec_grade, output ready);
endinterface

// result channel
interface mqlf_out_if;
    import mqlf_pkg::*;

    logic               valid;
    logic               ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]    out_id;
    logic [GRADE_W-1:0] out_grade;
    logic               now_empty;

    modport source (output valid, status, out_id, out_grade, now_empty, input ready);
    modport sink   (input valid, status, out_id, out_grade, now_empty, output ready);
endinterface

// ----- design/mqlf_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqlf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mqlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/multi_queue_linked_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_linked_fifo
// Several FIFO queues linked through one shared pool of record slots.
//
//   channel  dir  handshake      word
//   i_in     in   valid/ready    mode, queue_sel, rec_id, rec_grade
//   o_out    out  valid/ready    status, out_id, out_grade, now_empty
//
// Each operation takes two steps: the accept cycle issues the reads of the
// record, link and free-stack memories, and the update step then applies the
// update, as the memories have registered reads.
// Reset is synchronous; no clearing pass, unused slots come from a fill count.
// A stalled result holds the update cycle until the output register frees.
// ----------------------------------------------------------------------------
module multi_queue_linked_fifo #(
    parameter int NUM_QUEUES = mqlf_pkg::NUM_QUEUES_DEF,
    parameter int POOL_DEPTH = mqlf_pkg::POOL_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mqlf_in_if.sink     i_in,
    mqlf_out_if.source  o_out
);
    import mqlf_pkg::*;

    localparam int AW  = $clog2(POOL_DEPTH);
    localparam int CW  = $clog2(POOL_DEPTH + 1);
    localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int QXW = QIW + QSEL_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // control
    logic                r_state;
    logic                r_mode;
    logic                r_q_ok;
    logic [QIW-1:0]      r_qi;
    logic [ID_W-1:0]     r_id;
    logic [GRADE_W-1:0]  r_grade;

    // per-queue pointers and occupancy
    logic [AW-1:0]         r_head [NUM_QUEUES];
    logic [AW-1:0]         r_tail [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] r_busy;

    // free pool: never-used slots counted up, recycled slots on a stack
    logic [CW-1:0] r_fresh;
    logic [CW-1:0] r_top;

    // output register
    logic                r_out_valid;
    t_status             r_out_status;
    logic [ID_W-1:0]     r_out_id;
    logic [GRADE_W-1:0]  r_out_grade;
    logic                r_out_empty;

    logic [QXW-1:0]  sel_ext;
    logic            sel_ok;
    logic [QIW-1:0]  sel_idx;
    logic            in_fire;
    logic            out_free;
    logic            exec_go;
    logic            have_free;
    logic            enq_ok;
    logic            deq_ok;
    logic            last_rec;
    logic [AW-1:0]   slot;
    logic [REC_W-1:0] rec_rdata;
    logic [AW-1:0]   link_rdata;
    logic [AW-1:0]   fs_rdata;
    logic [CW-1:0]   top_dec;

    t_status             n_status;
    logic [ID_W-1:0]     n_id;
    logic [GRADE_W-1:0]  n_grade;
    logic                n_empty;

    // input decode
    assign sel_ext = {{QIW{1'b0}}, i_in.queue_sel};
    assign sel_ok  = (sel_ext < QXW'(NUM_QUEUES));
    assign sel_idx = sel_ok ? sel_ext[QIW-1:0] : '0;
    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;

    // update step gating
    assign out_free = !r_out_valid || o_out.ready;
    assign exec_go  = (r_state == S_EXEC) && out_free;

    assign top_dec   = r_top - CW'(1);
    assign have_free = (r_top != '0) || (r_fresh != CW'(POOL_DEPTH));
    assign enq_ok    = r_q_ok && (r_mode == MODE_ENQ) && have_free;
    assign deq_ok    = r_q_ok && (r_mode == MODE_DEQ) && r_busy[r_qi];
    assign last_rec  = (r_head[r_qi] == r_tail[r_qi]);
    assign slot      = (r_top != '0) ? fs_rdata : r_fresh[AW-1:0];

    // record store
    mqlf_ram #(.WIDTH(REC_W), .DEPTH(POOL_DEPTH)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (exec_go && enq_ok),
        .i_waddr (slot),
        .i_wdata ({r_id, r_grade}),
        .i_re    (in_fire),
        .i_raddr (r_head[sel_idx]),
        .o_rdata (rec_rdata)
    );

    // next links
    mqlf_ram #(.WIDTH(AW), .DEPTH(POOL_DEPTH)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (exec_go && enq_ok && r_busy[r_qi]),
        .i_waddr (r_tail[r_qi]),
        .i_wdata (slot),
        .i_re    (in_fire),
        .i_raddr (r_head[sel_idx]),
        .o_rdata (link_rdata)
    );

    // recycled slot stack
    mqlf_ram #(.WIDTH(AW), .DEPTH(POOL_DEPTH)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (exec_go && deq_ok),
        .i_waddr (r_top[AW-1:0]),
        .i_wdata (r_head[r_qi]),
        .i_re    (in_fire),
        .i_raddr (top_dec[AW-1:0]),
        .o_rdata (fs_rdata)
    );

    // result word
    always_comb begin
        n_status = ST_OK;
        n_id     = '0;
        n_grade  = '0;
        n_empty  = 1'b1;
        if (!r_q_ok) begin
            n_status = (r_mode == MODE_DEQ) ? ST_EMPTY : ST_FULL;
        end else if (r_mode == MODE_ENQ) begin
            n_status = enq_ok ? ST_OK : ST_FULL;
            n_empty  = enq_ok ? 1'b0 : !r_busy[r_qi];
        end else if (deq_ok) begin
            n_id    = rec_rdata[REC_W-1:GRADE_W];
            n_grade = rec_rdata[GRADE_W-1:0];
            n_empty = last_rec;
        end else begin
            n_status = ST_EMPTY;
        end
    end

    // sequencer, pointers and free pool
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_busy      <= '0;
            r_fresh     <= '0;
            r_top       <= '0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
            end
        end else begin
            // output word held until taken
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_go) begin
                        r_state <= S_IDLE;
                        if (enq_ok) begin
                            if (r_top != '0) begin
                                r_top <= top_dec;
                            end else begin
                                r_fresh <= r_fresh + CW'(1);
                            end
                            if (!r_busy[r_qi]) begin
                                r_head[r_qi] <= slot;
                            end
                            r_tail[r_qi] <= slot;
                            r_busy[r_qi] <= 1'b1;
                        end
                        if (deq_ok) begin
                            r_top <= r_top + CW'(1);
                            if (last_rec) begin
                                r_head[r_qi] <= '0;
                                r_tail[r_qi] <= '0;
                                r_busy[r_qi] <= 1'b0;
                            end else begin
                                r_head[r_qi] <= link_rdata;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // captured operation and result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mode  <= i_in.mode;
            r_q_ok  <= sel_ok;
            r_qi    <= sel_idx;
            r_id    <= i_in.rec_id;
            r_grade <= i_in.rec_grade;
        end
        if (exec_go) begin
            r_out_status <= n_status;
            r_out_id     <= n_id;
            r_out_grade  <= n_grade;
            r_out_empty  <= n_empty;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out_status;
    assign o_out.out_id    = r_out_id;
    assign o_out.out_grade = r_out_grade;
    assign o_out.now_empty = r_out_empty;

    // recycled slots can never outnumber slots handed out
    a_top_le_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= r_fresh)
        else $error("free stack deeper than slots ever allocated");

    // fresh counter stays within the pool
    a_fresh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= CW'(POOL_DEPTH))
        else $error("fresh slot counter beyond pool depth");

    // a result appears only from the update step
    a_out_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_state == S_EXEC))
        else $error("result without an update step");

    // a successful dequeue always returns a slot to the stack
    a_deq_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_go && deq_ok) |=> (r_top == $past(r_top) + CW'(1)))
        else $error("dequeue did not recycle its slot");

endmodule

// ----- tb/sv/tb_multi_queue_linked_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_queue_linked_fifo
// Self-checking bench for the multi-queue linked FIFO. A driver process sends
// enqueue/dequeue words from a backlog and updates a behavioral copy of the
// queues, free stack and slot memory on every accepted word. A monitor process
// compares each result word field by field with the oldest predicted reply.
// Directed corner cases come first, then random phases that fill the shared
// pool to overflow, drain it to underflow and mix both, with random stalls on
// both channels.
// ----------------------------------------------------------------------------
module tb_multi_queue_linked_fifo;
    import mqlf_pkg::*;

    localparam int NQ   = NUM_QUEUES_DEF;
    localparam int POOL = POOL_DEPTH_DEF;

    // one queue operation as offered on the input channel
    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [QSEL_W-1:0]  qsel;
        logic [ID_W-1:0]    id;
        logic [GRADE_W-1:0] grade;
        bit                 drain_first;
        bit                 gaps_on;
    } t_op_word;

    // one result word
    typedef struct {
        t_status            status;
        logic [ID_W-1:0]    id;
        logic [GRADE_W-1:0] grade;
        logic               empty;
    } t_reply_word;

    logic i_clk;
    logic i_rst_n;

    mqlf_in_if  op_ch ();
    mqlf_out_if res_ch ();

    multi_queue_linked_fifo #(
        .NUM_QUEUES (NQ),
        .POOL_DEPTH (POOL)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_ch),
        .o_out   (res_ch)
    );

    // clock, 2 ns period
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // behavioral copy of the queue state
    logic [REC_W-1:0] slot_rec   [POOL];
    int unsigned      slot_next  [POOL];
    int unsigned      free_slots [POOL];
    int unsigned      head_slot  [NQ];
    int unsigned      tail_slot  [NQ];
    int unsigned      q_len      [NQ];
    int unsigned      free_top;

    t_op_word     op_backlog[$];
    t_reply_word  pending_replies[$];
    t_op_word     cur_op;
    int unsigned  ops_accepted;
    int unsigned  replies_seen;
    int unsigned  fail_count;
    int unsigned  tx_gap;
    int unsigned  rx_stall;
    int unsigned  rx_cycle;
    bit           long_hold_done;

    // gap length: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_op(logic [MODE_W-1:0] mode, logic [QSEL_W-1:0] qsel,
                                   logic [ID_W-1:0] id, logic [GRADE_W-1:0] grade,
                                   bit drain_first, bit gaps_on);
        t_op_word w;
        w.mode        = mode;
        w.qsel        = qsel;
        w.id          = id;
        w.grade       = grade;
        w.drain_first = drain_first;
        w.gaps_on     = gaps_on;
        op_backlog.push_back(w);
    endfunction

    // apply one accepted operation to the queue copy and queue its reply
    function automatic void apply_queue_op(t_op_word w);
        t_reply_word r;
        int unsigned q;
        int unsigned s;
        q = 32'(w.qsel);
        r.status = ST_OK;
        r.id     = '0;
        r.grade  = '0;
        r.empty  = 1'b0;
        if (q >= NQ) begin
            // unknown queue: answered, state untouched
            r.status = (w.mode == MODE_DEQ) ? ST_EMPTY : ST_FULL;
            r.empty  = 1'b1;
        end else if (w.mode == MODE_ENQ) begin
            if (free_top == 0) begin
                r.status = ST_FULL;
                r.empty  = (q_len[q] == 0);
            end else begin
                free_top--;
                s = free_slots[free_top];
                slot_rec[s] = {w.id, w.grade};
                if (q_len[q] == 0) begin
                    head_slot[q] = s;
                end else begin
                    slot_next[tail_slot[q]] = s;
                end
                tail_slot[q] = s;
                q_len[q]++;
            end
        end else begin
            if (q_len[q] == 0) begin
                r.status = ST_EMPTY;
                r.empty  = 1'b1;
            end else begin
                s = head_slot[q];
                {r.id, r.grade} = slot_rec[s];
                q_len[q]--;
                // last record gone: head and tail return to slot 0
                if (q_len[q] == 0) begin
                    head_slot[q] = 0;
                    tail_slot[q] = 0;
                end else begin
                    head_slot[q] = slot_next[s];
                end
                free_slots[free_top] = s;
                free_top++;
                r.empty = (q_len[q] == 0);
            end
        end
        pending_replies.push_back(r);
    endfunction

    // compare one accepted result word with the oldest prediction
    function automatic void check_reply();
        t_reply_word want;
        replies_seen++;
        if (pending_replies.size() == 0) begin
            $error("result word with no prediction waiting: status %0d id %0h",
                   res_ch.status, res_ch.out_id);
            fail_count++;
            return;
        end
        want = pending_replies.pop_front();
        if (res_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res_ch.status);
            fail_count++;
        end
        if (res_ch.out_id !== want.id) begin
            $error("out_id: expected %0h, actual %0h", want.id, res_ch.out_id);
            fail_count++;
        end
        if (res_ch.out_grade !== want.grade) begin
            $error("out_grade: expected %0h, actual %0h", want.grade, res_ch.out_grade);
            fail_count++;
        end
        if (res_ch.now_empty !== want.empty) begin
            $error("now_empty: expected %0d, actual %0d", want.empty, res_ch.now_empty);
            fail_count++;
        end
    endfunction

    // driver: offers words from the backlog, predicts on each accept
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            op_ch.valid <= 1'b0;
        end else begin
            if (op_ch.valid && op_ch.ready) begin
                apply_queue_op(cur_op);
                ops_accepted++;
            end
            if (!op_ch.valid || op_ch.ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    op_ch.valid <= 1'b0;
                end else if (op_backlog.size() > 0 &&
                             !(op_backlog[0].drain_first && pending_replies.size() > 0)) begin
                    cur_op = op_backlog.pop_front();
                    op_ch.valid     <= 1'b1;
                    op_ch.mode      <= cur_op.mode;
                    op_ch.queue_sel <= cur_op.qsel;
                    op_ch.rec_id    <= cur_op.id;
                    op_ch.rec_grade <= cur_op.grade;
                    tx_gap = cur_op.gaps_on ? pick_gap() : 0;
                end else begin
                    op_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks results, stalls at random, one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                check_reply();
            end
            rx_cycle++;
            if (!long_hold_done && replies_seen >= 200) begin
                long_hold_done = 1'b1;
                rx_stall       = 400;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                // periodic calm stretch in which no new stalls start
                if ((rx_cycle % 500) >= 120) begin
                    rx_stall = pick_gap();
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int unsigned total;
        int unsigned enq_pct;
        int unsigned qs;
        bit          gaps;
        op_ch.valid     = 1'b0;
        op_ch.mode      = MODE_ENQ;
        op_ch.queue_sel = '0;
        op_ch.rec_id    = '0;
        op_ch.rec_grade = '0;
        res_ch.ready    = 1'b0;
        i_rst_n         = 1'b0;
        ops_accepted    = 0;
        replies_seen    = 0;
        fail_count      = 0;
        tx_gap          = 0;
        rx_stall        = 0;
        rx_cycle        = 0;
        long_hold_done  = 1'b0;

        // queue copy after reset
        for (int i = 0; i < POOL; i++) begin
            free_slots[i] = i;
            slot_rec[i]   = '0;
            slot_next[i]  = 0;
        end
        for (int i = 0; i < NQ; i++) begin
            head_slot[i] = 0;
            tail_slot[i] = 0;
            q_len[i]     = 0;
        end
        free_top = POOL;

        // dequeue from every empty queue
        for (int i = 0; i < NQ; i++) begin
            add_op(MODE_DEQ, QSEL_W'(i), 16'h0, 8'h0, 1'b0, 1'b1);
        end
        // unknown queue, both operations
        add_op(MODE_ENQ, 2'd3, 16'hffff, 8'hff, 1'b0, 1'b1);
        add_op(MODE_DEQ, 2'd3, 16'hffff, 8'hff, 1'b0, 1'b1);
        // field extremes and every queue
        add_op(MODE_ENQ, 2'd0, 16'h0000, 8'h00, 1'b0, 1'b0);
        add_op(MODE_ENQ, 2'd0, 16'hffff, 8'hff, 1'b0, 1'b0);
        add_op(MODE_ENQ, 2'd1, 16'h5555, 8'haa, 1'b0, 1'b0);
        add_op(MODE_ENQ, 2'd2, 16'haaaa, 8'h55, 1'b0, 1'b0);
        add_op(MODE_ENQ, 2'd1, 16'h8001, 8'h80, 1'b0, 1'b0);
        // empty queue 0, then reuse it after its tail was cleared
        add_op(MODE_DEQ, 2'd0, 16'h1111, 8'h11, 1'b0, 1'b1);
        add_op(MODE_DEQ, 2'd0, 16'h2222, 8'h22, 1'b0, 1'b1);
        add_op(MODE_DEQ, 2'd0, 16'h0, 8'h0, 1'b0, 1'b1);
        add_op(MODE_ENQ, 2'd0, 16'h1234, 8'h56, 1'b0, 1'b1);
        add_op(MODE_ENQ, 2'd0, 16'h7fff, 8'h7f, 1'b0, 1'b1);
        add_op(MODE_DEQ, 2'd0, 16'h0, 8'h0, 1'b0, 1'b1);
        add_op(MODE_DEQ, 2'd1, 16'h0, 8'h0, 1'b0, 1'b1);
        add_op(MODE_DEQ, 2'd1, 16'h0, 8'h0, 1'b0, 1'b1);
        add_op(MODE_DEQ, 2'd2, 16'h0, 8'h0, 1'b0, 1'b1);
        // sender waits here until all replies are in
        add_op(MODE_DEQ, 2'd0, 16'h0, 8'h0, 1'b1, 1'b1);
        add_op(MODE_DEQ, 2'd2, 16'h0, 8'h0, 1'b0, 1'b1);

        // random phases: fill, fill, mix, drain, drain, ...
        for (int p = 0; p < 7; p++) begin
            case (p % 5)
                0, 1:    enq_pct = 85;
                2:       enq_pct = 50;
                default: enq_pct = 20;
            endcase
            gaps = (p % 3) != 1;
            for (int k = 0; k < 90; k++) begin
                qs = ($urandom_range(0, 99) < 6) ? 3 : $urandom_range(0, NQ - 1);
                add_op(($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ,
                       QSEL_W'(qs),
                       ID_W'($urandom_range(0, 16'hffff)),
                       GRADE_W'($urandom_range(0, 8'hff)),
                       (p == 4 && k == 0), gaps);
            end
        end
        total = op_backlog.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_accepted < total) @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

endmodule
